@@ design/jpdtc_pkg.sv @@
// Shared types and constants of the joint PD torque controller.
// Used by the register block, the top level and the checker.
package jpdtc_pkg;

  localparam int JOINT_COUNT_DEFAULT = 64;

  localparam int JOINT_W  = 6;
  localparam int VALUE_W  = 32;
  localparam int PGAIN_W  = 40;
  localparam int DGAIN_W  = 48;
  localparam int LIMIT_W  = 31;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;

  localparam logic [PGAIN_W-1:0] PROP_GAIN_RESET  = 40'd196608000;
  localparam logic [DGAIN_W-1:0] DERIV_GAIN_RESET = 48'd13107200000;
  localparam logic [LIMIT_W-1:0] TORQUE_LIMIT_RESET = 31'd32768000;

  typedef enum logic [1:0] {
    REG_PROP_GAIN    = 2'd0,
    REG_DERIV_GAIN   = 2'd1,
    REG_TORQUE_LIMIT = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [PGAIN_W-1:0] prop_gain;
    logic [DGAIN_W-1:0] deriv_gain_per_step;
    logic [LIMIT_W-1:0] torque_limit;
  } cfg_t;

endpackage

@@ design/jpdtc_regs.sv @@
// APB register file of the joint PD torque controller: gains and torque limit.
// Depends on jpdtc_pkg.
module jpdtc_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [jpdtc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [jpdtc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [jpdtc_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output jpdtc_pkg::cfg_t                 cfg
);
  import jpdtc_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain           <= PROP_GAIN_RESET;
      cfg.deriv_gain_per_step <= DERIV_GAIN_RESET;
      cfg.torque_limit        <= TORQUE_LIMIT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_PROP_GAIN:    cfg.prop_gain           <= pwdata[PGAIN_W-1:0];
        REG_DERIV_GAIN:   cfg.deriv_gain_per_step <= pwdata[DGAIN_W-1:0];
        REG_TORQUE_LIMIT: cfg.torque_limit        <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PROP_GAIN:    prdata = APB_DATA_W'(cfg.prop_gain);
      REG_DERIV_GAIN:   prdata = APB_DATA_W'(cfg.deriv_gain_per_step);
      REG_TORQUE_LIMIT: prdata = APB_DATA_W'(cfg.torque_limit);
      default:          prdata = '0;
    endcase
  end

endmodule

@@ design/joint_pd_torque_control.sv @@
// Top level of the joint PD torque controller: per-joint history memory,
// six-stage arithmetic pipeline and output clamp. Depends on jpdtc_pkg, jpdtc_regs.
//
// Usage:
//   Input stream s_*: one joint sample per transfer (joint index, position,
//   reference, all positions signed Q16.16). Output stream m_*: one result
//   per sample, in order (joint number, clamped torque Q16.16, clamp flag).
//   APB port: prop_gain at 0x00, deriv_gain_per_step at 0x08, torque_limit
//   at 0x10; write only while no sample is in flight.
//   Throughput: one sample per cycle while m_tready is high. The history memory
//   is read and written at the accepting edge, so samples of the same joint may
//   follow back to back. Pipeline: the memory read, the difference stage, split
//   gain products (gains split at bit 24), product combine, final sum and the
//   clamp/output register.
//   Stall: each stage holds while its successor is full and stalled; bubbles
//   collapse, so up to six samples are buffered before s_tready drops.
//   Reset: clears the pipeline, the joint-seen flags and restores the default
//   gains and limit; the history memory needs no clearing.
module joint_pd_torque_control #(
  parameter int JOINT_COUNT = jpdtc_pkg::JOINT_COUNT_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [5:0] joint_index, [37:6] position, [69:38] reference, [71:70] zero
  input  logic [jpdtc_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [5:0] joint_number, [37:6] torque, [39:38] zero
  output logic [jpdtc_pkg::OUT_TDATA_W-1:0] m_tdata,
  // [0] clamped
  output logic                             m_tuser,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [jpdtc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [jpdtc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [jpdtc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import jpdtc_pkg::*;

  localparam int AW     = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int SUM_W  = 84;
  localparam int SH_W   = SUM_W - 16;

  cfg_t cfg;

  jpdtc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input unpack
  logic [JOINT_W-1:0]        in_joint;
  logic signed [VALUE_W-1:0] in_pos;
  logic signed [VALUE_W-1:0] in_ref;
  logic                      in_ok;
  logic [AW-1:0]             addr;
  logic                      accept;

  assign in_joint = s_tdata[5:0];
  assign in_pos   = s_tdata[37:6];
  assign in_ref   = s_tdata[69:38];
  assign in_ok    = int'(in_joint) < JOINT_COUNT;
  assign addr     = AW'(in_joint);

  // stage handshake
  logic [6:1] v;
  logic [6:1] rdy;

  assign rdy[6] = !v[6] || m_tready;
  assign rdy[5] = !v[5] || rdy[6];
  assign rdy[4] = !v[4] || rdy[5];
  assign rdy[3] = !v[3] || rdy[4];
  assign rdy[2] = !v[2] || rdy[3];
  assign rdy[1] = !v[1] || rdy[2];

  assign s_tready = rdy[1];
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= s_tvalid;
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
      if (rdy[4]) v[4] <= v[3];
      if (rdy[5]) v[5] <= v[4];
      if (rdy[6]) v[6] <= v[5];
    end
  end

  // history memory: {reference, position}, read-first at the accepting edge
  logic [2*VALUE_W-1:0] hist_mem [JOINT_COUNT];
  logic [2*VALUE_W-1:0] hist_rd;
  logic [JOINT_COUNT-1:0] seen;
  logic                   seen_rd;

  always_ff @(posedge clk) begin
    if (accept) begin
      hist_rd <= hist_mem[addr];
      if (in_ok) hist_mem[addr] <= {in_ref, in_pos};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (accept && in_ok) begin
      seen[addr] <= 1'b1;
    end
  end

  // stage 1
  logic [JOINT_W-1:0]        s1_joint;
  logic signed [VALUE_W-1:0] s1_pos;
  logic signed [VALUE_W-1:0] s1_ref;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_joint <= in_joint;
      s1_pos   <= in_pos;
      s1_ref   <= in_ref;
      seen_rd  <= in_ok && seen[addr];
    end
  end

  // stage 2: errors
  logic signed [VALUE_W-1:0] prev_pos;
  logic signed [VALUE_W-1:0] prev_ref;
  logic signed [33:0]        d_next;
  logic [JOINT_W-1:0]        s2_joint;
  logic signed [32:0]        s2_ep;
  logic signed [33:0]        s2_d;

  assign prev_pos = hist_rd[VALUE_W-1:0];
  assign prev_ref = hist_rd[2*VALUE_W-1:VALUE_W];
  assign d_next = seen_rd ?
                  (34'(s1_ref) - 34'(prev_ref)) - (34'(s1_pos) - 34'(prev_pos)) : '0;

  always_ff @(posedge clk) begin
    if (rdy[2] && v[1]) begin
      s2_joint <= s1_joint;
      s2_ep    <= 33'(s1_ref) - 33'(s1_pos);
      s2_d     <= d_next;
    end
  end

  // stage 3: partial products on gain slices split at bit 24
  logic [JOINT_W-1:0] s3_joint;
  logic signed [57:0] s3_p_lo;
  logic signed [49:0] s3_p_hi;
  logic signed [58:0] s3_d_lo;
  logic signed [58:0] s3_d_hi;

  always_ff @(posedge clk) begin
    if (rdy[3] && v[2]) begin
      s3_joint <= s2_joint;
      s3_p_lo  <= 58'($signed({1'b0, cfg.prop_gain[23:0]})) * 58'(s2_ep);
      s3_p_hi  <= 50'($signed({1'b0, cfg.prop_gain[39:24]})) * 50'(s2_ep);
      s3_d_lo  <= 59'($signed({1'b0, cfg.deriv_gain_per_step[23:0]})) * 59'(s2_d);
      s3_d_hi  <= 59'($signed({1'b0, cfg.deriv_gain_per_step[47:24]})) * 59'(s2_d);
    end
  end

  // stage 4: combine slices
  logic [JOINT_W-1:0]      s4_joint;
  logic signed [SUM_W-1:0] s4_p;
  logic signed [SUM_W-1:0] s4_d;

  always_ff @(posedge clk) begin
    if (rdy[4] && v[3]) begin
      s4_joint <= s3_joint;
      s4_p     <= SUM_W'(s3_p_lo) + (SUM_W'(s3_p_hi) <<< 24);
      s4_d     <= SUM_W'(s3_d_lo) + (SUM_W'(s3_d_hi) <<< 24);
    end
  end

  // stage 5: final sum
  logic [JOINT_W-1:0]      s5_joint;
  logic signed [SUM_W-1:0] s5_sum;

  always_ff @(posedge clk) begin
    if (rdy[5] && v[4]) begin
      s5_joint <= s4_joint;
      s5_sum   <= s4_p + s4_d;
    end
  end

  // stage 6: scale, clamp, output register
  logic signed [SH_W-1:0]    sh;
  logic signed [SH_W-1:0]    lim;
  logic                      over;
  logic                      under;
  logic [VALUE_W-1:0]        tq_next;
  logic [JOINT_W-1:0]        out_joint;
  logic [VALUE_W-1:0]        out_torque;
  logic                      out_clamped;

  assign sh    = SH_W'(s5_sum >>> 16);
  assign lim   = $signed(SH_W'(cfg.torque_limit));
  assign over  = sh > lim;
  assign under = sh < -lim;

  always_comb begin
    if (over) begin
      tq_next = VALUE_W'(lim);
    end else if (under) begin
      tq_next = VALUE_W'(-lim);
    end else begin
      tq_next = sh[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6] && v[5]) begin
      out_joint   <= s5_joint;
      out_torque  <= tq_next;
      out_clamped <= over || under;
    end
  end

  assign m_tvalid = v[6];
  assign m_tdata  = {2'b00, out_torque, out_joint};
  assign m_tuser  = out_clamped;

endmodule

@@ design/jpdtc_checker.sv @@
// Port-level checker of the joint PD torque controller and its bind.
// Depends on jpdtc_pkg and joint_pd_torque_control.
module jpdtc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [jpdtc_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                             m_tuser
);

  // drop output valid after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // torque never reaches the most negative code
  a_torque_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[37:6] != 32'h8000_0000)
    else $error("torque outside symmetric range");

  // an accepted transfer reaches the output when the sink keeps up meanwhile
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
    ##1 m_tready |=> m_tvalid)
    else $error("result missing after pipeline latency");

endmodule

bind joint_pd_torque_control jpdtc_checker u_jpdtc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ verif/joint_pd_torque_control_tb.sv @@
// Testbench for joint_pd_torque_control: drives joint samples and APB gain writes,
// predicts each clamped torque in a scoreboard and checks the output stream.
// Depends on jpdtc_pkg and the joint_pd_torque_control RTL.
module joint_pd_torque_control_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jpdtc_pkg::*;

  localparam int JOINTS = JOINT_COUNT_DEFAULT;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 270;

  typedef struct {
    logic [JOINT_W-1:0] joint;
    logic [VALUE_W-1:0] torque;
    logic               clamped;
  } torque_result_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_t;

  class torque_scoreboard;
    logic [PGAIN_W-1:0] prop_gain;
    logic [DGAIN_W-1:0] deriv_gain;
    logic [LIMIT_W-1:0] torque_limit;
    logic [VALUE_W-1:0] last_position [JOINTS];
    logic [VALUE_W-1:0] last_target [JOINTS];
    bit                 joint_seen [JOINTS];
    torque_result_t     torque_q [$];
    int                 errors;

    function new();
      prop_gain = PROP_GAIN_RESET;
      deriv_gain = DERIV_GAIN_RESET;
      torque_limit = TORQUE_LIMIT_RESET;
      errors = 0;
      foreach (joint_seen[i]) joint_seen[i] = 1'b0;
    endfunction

    function void set_register(logic [1:0] idx, logic [63:0] value);
      case (idx)
        REG_PROP_GAIN:    prop_gain = value[PGAIN_W-1:0];
        REG_DERIV_GAIN:   deriv_gain = value[DGAIN_W-1:0];
        REG_TORQUE_LIMIT: torque_limit = value[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [JOINT_W-1:0] joint, logic signed [31:0] pos,
                              logic signed [31:0] target);
      logic signed [31:0] prev_pos, prev_target;
      logic signed [99:0] err, derr;
      logic signed [99:0] kp, kd, sum, scaled, lim, neg_lim;
      torque_result_t res;
      prev_pos = pos;
      prev_target = target;
      if (int'(joint) < JOINTS && joint_seen[joint]) begin
        prev_pos = last_position[joint];
        prev_target = last_target[joint];
      end
      err = 100'(target) - 100'(pos);
      derr = (100'(target) - 100'(prev_target)) - (100'(pos) - 100'(prev_pos));
      kp = 100'(prop_gain);
      kd = 100'(deriv_gain);
      sum = kp * err + kd * derr;
      scaled = sum >>> 16;
      lim = 100'(torque_limit);
      neg_lim = -lim;
      res.joint = joint;
      if (scaled > lim) begin
        res.torque = lim[31:0];
        res.clamped = 1'b1;
      end else if (scaled < neg_lim) begin
        res.torque = neg_lim[31:0];
        res.clamped = 1'b1;
      end else begin
        res.torque = scaled[31:0];
        res.clamped = 1'b0;
      end
      if (int'(joint) < JOINTS) begin
        last_position[joint] = pos;
        last_target[joint] = target;
        joint_seen[joint] = 1'b1;
      end
      torque_q = {torque_q, res};
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_result(logic [JOINT_W-1:0] joint, logic [31:0] torque,
                               logic clamped);
      torque_result_t want;
      if (torque_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual joint %0d torque %0h",
                 $time, joint, torque);
        return;
      end
      want = torque_q.pop_front();
      if (joint !== want.joint) flag("joint_number", 32'(want.joint), 32'(joint));
      if (torque !== want.torque) flag("torque", want.torque, torque);
      if (clamped !== want.clamped) flag("clamped", 32'(want.clamped), 32'(clamped));
    endfunction

    function int pending();
      return torque_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  torque_scoreboard board;
  logic signed [31:0] track [JOINTS];

  joint_pd_torque_control dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_result(m_tdata[5:0], m_tdata[37:6], m_tuser);
  end

  rx_mode_t rx_mode = RX_OPEN;
  int rx_window = 0;
  int rx_hold = 0;
  int rx_cycle = 0;

  always @(posedge clk) begin
    logic ready_next;
    ready_next = 1'b1;
    rx_cycle <= rx_cycle + 1;
    if (rx_window == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_window <= $urandom_range(20, 80);
    end else begin
      rx_window <= rx_window - 1;
    end
    if (rx_hold != 0) begin
      ready_next = 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      case (rx_mode)
        RX_RANDOM:   ready_next = ($urandom_range(0, 9) < 7);
        RX_PERIODIC: ready_next = (rx_cycle % 4 != 3);
        RX_BURSTY: begin
          if ($urandom_range(0, 11) == 0) begin
            rx_hold <= $urandom_range(7, 14);
            ready_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
    m_tready <= ready_next;
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("joint_pd_torque_control_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic [JOINT_W-1:0] joint, input logic [31:0] pos,
                             input logic [31:0] target);
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, target, pos, joint};
    do @(posedge clk); while (!s_tready);
    board.note_sample(joint, pos, target);
  endtask

  task automatic idle_sender(input int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_register(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [63:0] kp, input logic [63:0] kd,
                           input logic [63:0] lim);
    apb_write(REG_PROP_GAIN, kp);
    apb_write(REG_DERIV_GAIN, kd);
    apb_write(REG_TORQUE_LIMIT, lim);
  endtask

  function automatic logic [63:0] random_span();
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  function automatic logic [31:0] corner_value();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0001;
      default: return 32'h0;
    endcase
  endfunction

  task automatic send_random_items(input int count);
    logic [JOINT_W-1:0] pool [4];
    logic [JOINT_W-1:0] joint;
    logic [31:0] pos, target;
    int burst_left, gap, pick;
    foreach (pool[i]) pool[i] = JOINT_W'($urandom_range(0, JOINTS - 1));
    burst_left = 0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 7) joint = pool[$urandom_range(0, 3)];
      else joint = JOINT_W'($urandom_range(0, JOINTS - 1));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        pos = $urandom;
        target = $urandom;
      end else if (pick < 16) begin
        pos = corner_value();
        target = corner_value();
      end else begin
        track[joint] = track[joint] + ($signed($urandom) >>> $urandom_range(8, 31));
        pos = track[joint] + ($signed($urandom) >>> $urandom_range(12, 31));
        target = track[joint] + ($signed($urandom) >>> $urandom_range(12, 31));
      end
      send_sample(joint, pos, target);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) idle_sender(gap);
      end else begin
        burst_left--;
      end
    end
    idle_sender(1);
  endtask

  initial begin
    board = new();
    foreach (track[i]) track[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // default gains: first samples, repeats of a joint, full-scale errors
    send_sample(6'd0, 32'h0, 32'h0);
    send_sample(6'd0, 32'h0, 32'h100);
    send_sample(6'd63, 32'h7fff_ffff, 32'h8000_0000);
    send_sample(6'd63, 32'h8000_0000, 32'h7fff_ffff);
    send_sample(6'd1, 32'h7fff_ffff, 32'h7fff_ffff);
    send_sample(6'd1, 32'h7fff_fff0, 32'h7fff_ffff);
    send_sample(6'd2, 32'hffff_ffff, 32'h0);
    idle_sender(1);
    drain();

    // unit proportional gain: torque at, and one past, the limit
    configure(64'h1_0000, 64'h0, 64'd1000);
    apb_write(REG_UNUSED, {$urandom, $urandom});
    send_sample(6'd3, 32'd0, 32'd1000);
    send_sample(6'd3, 32'd1000, 32'd0);
    send_sample(6'd3, 32'd0, 32'd1001);
    send_sample(6'd3, 32'd1001, 32'd0);
    send_sample(6'd3, 32'd7, 32'd7);
    idle_sender(1);
    drain();

    // derivative only, zero limit
    configure(64'h0, 64'h1_0000, 64'h0);
    send_sample(6'd5, 32'd0, 32'd0);
    send_sample(6'd5, 32'd0, 32'd10);
    send_sample(6'd5, 32'd0, 32'd5);
    send_sample(6'd5, 32'd0, 32'd5);
    idle_sender(1);
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: configure(PROP_GAIN_RESET, DERIV_GAIN_RESET, TORQUE_LIMIT_RESET);
        1: configure('1, '1, '1);
        2: configure(64'h0, 64'h0, random_span());
        3: configure(random_span(), random_span(), '1);
        default: configure(random_span(), random_span(), random_span());
      endcase
      send_random_items(ITEMS_PER_PHASE);
      drain();
    end

    if (board.errors == 0) begin
      $display("joint_pd_torque_control_tb: done, clean");
    end else begin
      $display("joint_pd_torque_control_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/jpdtc_pkg.sv
design/jpdtc_regs.sv
design/joint_pd_torque_control.sv
design/jpdtc_checker.sv
verif/joint_pd_torque_control_tb.sv
